[hw/rtl/adpcm_4bit_encoder_assert.svh]
// Assertion macros used by the checker file.
// Each expects signals named clk and rst_n in the scope of use.
`ifndef ADPCM_4BIT_ENCODER_ASSERT_SVH
`define ADPCM_4BIT_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define A4ENC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define A4ENC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define A4ENC_ASSERT_DLY(lbl, ante, n, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

[hw/rtl/a4enc_pkg.sv]
package a4enc_pkg;

    localparam logic [14:0] STEP_MIN = 15'h007f;
    localparam logic [14:0] STEP_MAX = 15'h6000;

    typedef logic [2:0] upc_t;

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_SAT  = 3'd1,
        OP_DIV  = 3'd2,
        OP_PRED = 3'd3,
        OP_STEP = 3'd4
    } op_t;

    // One microcode word.
    typedef struct packed {
        op_t        op;
        logic [1:0] shift;
        logic       jmp_sat;
        upc_t       target;
        logic       done;
    } uword_t;

    // Control from sequencer to datapath.
    typedef struct packed {
        op_t        op;
        logic [1:0] shift;
        logic       en;
        logic       restart;
    } a4enc_ctrl_t;

    // Status from datapath to sequencer.
    typedef struct packed {
        logic       sat;
        logic [3:0] code;
    } a4enc_stat_t;

    localparam upc_t UPC_PRED = 3'd5;

    // Per-sample program: load, saturation test, three quotient bits,
    // predictor update, step update and hand-off.
    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        begin
            unique case (pc)
                3'd0:    w = '{op: OP_LOAD, shift: 2'd0, jmp_sat: 1'b0, target: 3'd0, done: 1'b0};
                3'd1:    w = '{op: OP_SAT,  shift: 2'd0, jmp_sat: 1'b1, target: UPC_PRED,
                               done: 1'b0};
                3'd2:    w = '{op: OP_DIV,  shift: 2'd2, jmp_sat: 1'b0, target: 3'd0, done: 1'b0};
                3'd3:    w = '{op: OP_DIV,  shift: 2'd1, jmp_sat: 1'b0, target: 3'd0, done: 1'b0};
                3'd4:    w = '{op: OP_DIV,  shift: 2'd0, jmp_sat: 1'b0, target: 3'd0, done: 1'b0};
                3'd5:    w = '{op: OP_PRED, shift: 2'd0, jmp_sat: 1'b0, target: 3'd0, done: 1'b0};
                default: w = '{op: OP_STEP, shift: 2'd0, jmp_sat: 1'b0, target: 3'd0, done: 1'b1};
            endcase
            return w;
        end
    endfunction

    // Step multiplier, indexed by the code magnitude.
    function automatic logic [9:0] scale(input logic [2:0] m);
        logic [9:0] s;
        begin
            unique case (m)
                3'd0, 3'd1, 3'd2, 3'd3: s = 10'h0e6;
                3'd4:                   s = 10'h133;
                3'd5:                   s = 10'h199;
                3'd6:                   s = 10'h200;
                default:                s = 10'h266;
            endcase
            return s;
        end
    endfunction

endpackage

[hw/rtl/a4enc_ifs.sv]
interface a4enc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample;
    logic        last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface a4enc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;

    modport source (output valid, output code_byte, output last_byte, input ready);
    modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

[hw/rtl/a4enc_dp.sv]
module a4enc_dp
    import a4enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  a4enc_ctrl_t ctrl,
    input  logic [15:0] sample,
    output a4enc_stat_t stat
);

    logic [15:0] pred_reg, pred_next;
    logic [14:0] step_reg, step_next;
    logic [17:0] rem_reg, rem_next;
    logic [2:0]  mag_reg, mag_next;
    logic        neg_reg, neg_next;

    logic [16:0] diff, diff_neg, abs17;
    logic [17:0] dvs;
    logic        ge_dvs;
    logic [18:0] prod_p;
    logic [15:0] delta;
    logic [17:0] psum;
    logic [24:0] prod_s;
    logic [16:0] sscaled;

    always_comb
    begin
        // Difference of masked sample and predictor, 17 bits two's complement
        diff     = {sample[15], sample[15:3], 3'b000} - {pred_reg[15], pred_reg};
        diff_neg = ~diff + 17'd1;
        abs17    = diff[16] ? diff_neg : diff;

        dvs    = {3'b000, step_reg} << ctrl.shift;
        ge_dvs = (rem_reg >= dvs);

        prod_p = step_reg * {mag_reg, 1'b1};
        delta  = prod_p[18:3];
        psum   = neg_reg ? ({{2{pred_reg[15]}}, pred_reg} - {2'b00, delta})
                         : ({{2{pred_reg[15]}}, pred_reg} + {2'b00, delta});

        prod_s  = step_reg * scale(mag_reg);
        sscaled = prod_s[24:8];

        stat.sat  = (rem_reg >= {step_reg, 3'b000});
        stat.code = {neg_reg, mag_reg};
    end

    always_comb
    begin
        pred_next = pred_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        if (ctrl.en)
        begin
            unique case (ctrl.op)
                OP_LOAD:
                begin
                    rem_next = {abs17[15:0], 2'b00};
                    mag_next = 3'd0;
                    // Sign only when eight times the magnitude reaches the step size
                    neg_next = diff[16] && ({abs17[15:0], 3'b000} >= {4'b0000, step_reg});
                end
                OP_SAT:
                begin
                    if (stat.sat)
                    begin
                        mag_next = 3'd7;
                    end
                end
                OP_DIV:
                begin
                    if (ge_dvs)
                    begin
                        rem_next = rem_reg - dvs;
                        mag_next = mag_reg | (3'd1 << ctrl.shift);
                    end
                end
                OP_PRED:
                begin
                    if (psum[17:15] == 3'b000 || psum[17:15] == 3'b111)
                    begin
                        pred_next = psum[15:0];
                    end
                    else
                    begin
                        pred_next = psum[17] ? 16'h8000 : 16'h7fff;
                    end
                end
                OP_STEP:
                begin
                    if (ctrl.restart)
                    begin
                        pred_next = 16'h0000;
                        step_next = STEP_MIN;
                    end
                    else if (sscaled < {2'b00, STEP_MIN})
                    begin
                        step_next = STEP_MIN;
                    end
                    else if (sscaled > {2'b00, STEP_MAX})
                    begin
                        step_next = STEP_MAX;
                    end
                    else
                    begin
                        step_next = sscaled[14:0];
                    end
                end
                default:
                begin
                    step_next = step_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg <= 16'h0000;
            step_reg <= STEP_MIN;
        end
        else
        begin
            pred_reg <= pred_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        mag_reg <= mag_next;
        neg_reg <= neg_next;
    end

endmodule

[hw/rtl/adpcm_4bit_encoder.sv]
// Each sample runs a microcode program, one datapath step per cycle unless the final step stalls
// while the previous byte is still waiting: load, saturation test, three quotient bits (skipped
// when the code saturates), predictor, step. The input takes no new sample until the program ends.
// Reset (rst_n low, asynchronous): predictor 0, step size 0x7f, no code held, output empty.
// The predictor and step size also return to these values after a sample marked last.
module adpcm_4bit_encoder
    import a4enc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    a4enc_in_if.sink      pcm,
    a4enc_out_if.source   codes
);

    // Sequencer state
    logic        busy_reg, busy_next;
    upc_t        upc_reg, upc_next;
    logic [15:0] sample_reg, sample_next;
    logic        last_reg, last_next;

    // Nibble packing
    logic        held_reg, held_next;
    logic [3:0]  held_code_reg, held_code_next;

    // Output register
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;

    uword_t      word;
    a4enc_ctrl_t ctrl;
    a4enc_stat_t stat;
    logic        accept, emit, stall, step_en, finish;

    a4enc_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .sample (sample_reg),
        .stat   (stat)
    );

    always_comb
    begin
        word   = ucode(upc_reg);
        accept = pcm.valid && !busy_reg;
        // A byte leaves on the second code of a pair or on the last sample
        emit   = held_reg || last_reg;
        // Hold the final step of a sample that emits a byte while the previous byte is still waiting
        stall  = word.done && emit && ovalid_reg && !codes.ready;
        step_en = busy_reg && !stall;
        finish  = step_en && word.done;

        ctrl.op      = word.op;
        ctrl.shift   = word.shift;
        ctrl.en      = step_en;
        ctrl.restart = last_reg;
    end

    always_comb
    begin
        busy_next      = busy_reg;
        upc_next       = upc_reg;
        sample_next    = sample_reg;
        last_next      = last_reg;
        held_next      = held_reg;
        held_code_next = held_code_reg;
        ovalid_next    = ovalid_reg && !codes.ready;
        obyte_next     = obyte_reg;
        olast_next     = olast_reg;

        if (accept)
        begin
            busy_next   = 1'b1;
            upc_next    = '0;
            sample_next = pcm.sample;
            last_next   = pcm.last_sample;
        end
        else if (step_en)
        begin
            priority if (word.done)
            begin
                busy_next = 1'b0;
            end
            else if (word.jmp_sat && stat.sat)
            begin
                // Saturated magnitude: skip the quotient bits
                upc_next = word.target;
            end
            else
            begin
                upc_next = upc_reg + 3'd1;
            end
        end

        if (finish)
        begin
            if (!emit)
            begin
                // First code of a pair: hold it for the low nibble
                held_code_next = stat.code;
                held_next      = 1'b1;
            end
            else
            begin
                ovalid_next = 1'b1;
                obyte_next  = held_reg ? {stat.code, held_code_reg} : {4'h0, stat.code};
                olast_next  = last_reg;
                held_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            upc_reg    <= '0;
            held_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            upc_reg    <= upc_next;
            held_reg   <= held_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        last_reg      <= last_next;
        held_code_reg <= held_code_next;
        obyte_reg     <= obyte_next;
        olast_reg     <= olast_next;
    end

    assign pcm.ready       = !busy_reg;
    assign codes.valid     = ovalid_reg;
    assign codes.code_byte = obyte_reg;
    assign codes.last_byte = olast_reg;

endmodule

[hw/rtl/a4enc_checker.sv]
`include "adpcm_4bit_encoder_assert.svh"

module a4enc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pcm_valid,
    input logic       pcm_ready,
    input logic       codes_valid,
    input logic       codes_ready,
    input logic [7:0] codes_code_byte,
    input logic       codes_last_byte
);

    // The shortest program (load, saturation test, predictor, step) still holds the input closed
    `A4ENC_ASSERT_DLY(a_busy_after_beat, pcm_valid && pcm_ready, 3, !pcm_ready, "input reopened too early")

    // A new byte only appears at the end of a sample's program
    `A4ENC_ASSERT_IMP(a_byte_from_work, $rose(codes_valid), $past(!pcm_ready), "byte without work")

    // A taken sample beat closes the input in the cycle after it
    `A4ENC_ASSERT_NXT(a_no_beat_idle, pcm_valid && pcm_ready, !pcm_ready, "beat not taken up")

    `A4ENC_ASSERT_NXT(a_out_hold, codes_valid && !codes_ready, codes_valid && $stable(codes_code_byte) && $stable(codes_last_byte), "stalled byte changed")

endmodule

bind adpcm_4bit_encoder a4enc_checker u_a4enc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pcm_valid       (pcm.valid),
    .pcm_ready       (pcm.ready),
    .codes_valid     (codes.valid),
    .codes_ready     (codes.ready),
    .codes_code_byte (codes.code_byte),
    .codes_last_byte (codes.last_byte)
);
